### sv/uart_cfp_pkg.sv
`default_nettype none
package uart_cfp_pkg;

	// Frame delimiters
	localparam logic [7:0] OPEN_BYTE  = 8'h52;
	localparam logic [7:0] CLOSE_BYTE = 8'h23;

	// Only the first twelve positions of a frame are kept and decoded
	localparam int unsigned STORE_LEN = 12;

	// Snapshot of the stored frame bytes, byte 0 in bits 7..0
	typedef logic [STORE_LEN-1:0][7:0] store_t;

endpackage
`default_nettype wire

### sv/uart_cfp_frame.sv
`default_nettype none
module uart_cfp_frame #(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           rx_byte_s1,
	output uart_cfp_pkg::store_t      store
);
	import uart_cfp_pkg::*;

	localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);

	store_t         store_q;
	logic [PW-1:0]  pos_q;
	logic           open_q;

	logic           open_n;
	logic [PW-1:0]  pos_r;
	logic [PW-1:0]  pos_n;
	logic           wr_en;

	// Open on 'R', close on '#', rewind the position on 'R'
	always_comb begin
		open_n = open_q;
		pos_r  = pos_q;
		if (rx_byte_s1 == OPEN_BYTE) begin
			open_n = 1'b1;
			pos_r  = '0;
		end
		if (rx_byte_s1 == CLOSE_BYTE) begin
			open_n = 1'b0;
		end
	end

	// Wrap at the buffer end and drop that byte, otherwise advance while open
	always_comb begin
		pos_n = pos_r;
		wr_en = 1'b0;
		if (pos_r >= PW'(BUFFER_DEPTH)) begin
			pos_n = '0;
		end else if (open_n) begin
			wr_en = (pos_r < PW'(STORE_LEN));
			pos_n = pos_r + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			open_q <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_n;
			open_q <= open_n;
		end
	end

	// Write the byte into its slot of the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (step && wr_en) begin
			for (int i = 0; i < STORE_LEN; i++) begin
				if (pos_r == PW'(i)) begin
					store_q[i] <= rx_byte_s1;
				end
			end
		end
	end

	assign store = store_q;

	// Position never runs past the buffer end
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(BUFFER_DEPTH))
		else $error("write position beyond buffer depth");

endmodule
`default_nettype wire

### sv/uart_cfp_result.sv
`default_nettype none
module uart_cfp_result (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 commit,
	input  wire uart_cfp_pkg::store_t store,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic [31:0]               command_code,
	output logic signed [7:0]         kind_out,
	output logic signed [7:0]         day_out,
	output logic signed [7:0]         month_out,
	output logic signed [7:0]         year_out
);
	import uart_cfp_pkg::*;

	logic [7:0] kept_kind_q;
	logic [7:0] kept_day_q;
	logic [7:0] kept_month_q;
	logic [7:0] kept_year_q;
	logic       out_valid_q;

	logic [7:0] dt_n;
	logic [7:0] day_n;
	logic [7:0] mon_n;
	logic [7:0] yr_n;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// Decode a two-character pair with text-to-integer rules
	function automatic logic [7:0] decode_pair(
		input logic [7:0] a,
		input logic [7:0] b,
		input logic [7:0] kept
	);
		logic [7:0] da;
		logic [7:0] db;
		logic [7:0] v;
		da = a - 8'h30;
		db = b - 8'h30;
		v  = '0;
		if (a == 8'h00) begin
			v = kept;
		end else if (is_digit(a)) begin
			v = is_digit(b) ? ((da << 3) + (da << 1) + db) : da;
		end else if (a == 8'h2B || a == 8'h2D || is_space(a)) begin
			if (is_digit(b)) begin
				v = (a == 8'h2D) ? (8'h00 - db) : db;
			end
		end
		return v;
	endfunction

	assign dt_n  = decode_pair(store[4],  store[5],  kept_kind_q);
	assign day_n = decode_pair(store[6],  store[7],  kept_day_q);
	assign mon_n = decode_pair(store[8],  store[9],  kept_month_q);
	assign yr_n  = decode_pair(store[10], store[11], kept_year_q);

	// Hold the last decoded values for pairs that start with a zero byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_kind_q  <= '0;
			kept_day_q   <= '0;
			kept_month_q <= '0;
			kept_year_q  <= '0;
		end else if (commit) begin
			kept_kind_q  <= dt_n;
			kept_day_q   <= day_n;
			kept_month_q <= mon_n;
			kept_year_q  <= yr_n;
		end
	end

	// Result register: load on commit, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= commit || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			command_code <= {store[3], store[2], store[1], store[0]};
			kind_out     <= dt_n;
			day_out      <= day_n;
			month_out    <= mon_n;
			year_out     <= yr_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### sv/uart_command_frame_parser.sv
// Command frame parser for a received byte stream.
// Input channel: rx_byte with in_valid / in_stall; one byte per transaction.
// Output channel: command_code and four decoded fields with out_valid /
// out_stall; one transaction per '#' byte.
// A byte is taken into an input register; when it leaves that register it
// updates the frame state and, for '#', loads the result register, from
// which the result is presented.
// Throughput is one byte per cycle unless a '#' waits on a stalled result;
// the frame state update and the decode of the stored pairs are combinational.
// When the receiver stalls with a result pending, bytes other than '#'
// keep flowing; a '#' waits in the input register and in_stall rises until
// the pending result is taken.
// Reset clears the frame store, the write position, the open flag and the
// kept field values; no result is pending after reset.
`default_nettype none
module uart_command_frame_parser #(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [31:0]             command_code,
	output logic signed [7:0]       kind_out,
	output logic signed [7:0]       day_out,
	output logic signed [7:0]       month_out,
	output logic signed [7:0]       year_out
);
	import uart_cfp_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       close_s1;
	logic       step;
	logic       commit;
	store_t     store;

	// Advance the held byte unless it is a close and the result slot is busy
	assign close_s1 = (rx_byte_s1 == CLOSE_BYTE);
	assign step     = valid_s1 && (!close_s1 || !out_valid || !out_stall);
	assign commit   = step && close_s1;
	assign in_stall = valid_s1 && !step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	uart_cfp_frame #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte_s1 (rx_byte_s1),
		.store      (store)
	);

	uart_cfp_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.store        (store),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.command_code (command_code),
		.kind_out     (kind_out),
		.day_out      (day_out),
		.month_out    (month_out),
		.year_out     (year_out)
	);

	// A new result only follows a close byte leaving the input register
	a_result_from_close: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && close_s1))
		else $error("result without a close byte");

	// Bytes other than close never back up
	a_no_stall_open: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !close_s1) |-> !in_stall)
		else $error("non-close byte stalled");

	// The input stalls only for a close byte blocked by a pending, stalled result
	a_close_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && close_s1))
		else $error("input stalled without a pending result");

	// A stalled close byte is still held on the next cycle
	a_close_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && close_s1))
		else $error("stalled close byte lost");

endmodule
`default_nettype wire
